[hdl/pfr_pkg.sv]
// Shared types, constants and codes of the packet frame reassembler.
package pfr_pkg;

    // Datagram header: frame id byte, then a 4-byte little-endian packet index
    localparam int HEADER_BYTES = 5;

    // Defaults of the top level parameters
    localparam int MAX_PACKETS_DEF = 1024;
    localparam int STORE_BYTES_DEF = 1048576;

    // Field widths
    localparam int PPF_W   = 11;
    localparam int PM_W    = 16;
    localparam int TOTAL_W = 21;
    localparam int POS_W   = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [POS_W-1:0]   POS_MAX   = {POS_W{1'b1}};

    // Configuration reset values
    localparam logic [PPF_W-1:0]   PPF_RST = 11'd1024;
    localparam logic [PM_W-1:0]    PM_RST  = 16'd1400;
    localparam logic [TOTAL_W-1:0] FB_RST  = 21'd921600;

    // Configuration register word index (paddr[3:2])
    localparam logic [1:0] REG_PPF = 2'd0;
    localparam logic [1:0] REG_PM  = 2'd1;
    localparam logic [1:0] REG_FB  = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_RANGE     = 3'd2,
        ST_SHORT     = 3'd3,
        ST_COMPLETE  = 3'd4,
        ST_READ      = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    // Classification of one item, handed from front to back
    typedef struct packed {
        logic is_read;      // store read request
        logic hdr_done;     // last header byte
        logic payload;      // payload byte
        logic last;         // datagram ends with this item
        logic short_dgram;  // datagram ended inside the header
        logic in_window;    // payload offset below payload_max
        logic in_range;     // packet index within the frame
        logic rd_in_range;  // read address within the store
    } op_flags_t;

    // One result item
    typedef struct packed {
        status_t              status;
        logic [7:0]           frame_id;
        logic [31:0]          packet_index;
        logic [PPF_W-1:0]     packets_received;
        logic [TOTAL_W-1:0]   bytes_received;
        logic                 length_ok;
        logic [7:0]           read_byte;
    } res_t;

endpackage

[hdl/pfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfr_ram
    import pfr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

[hdl/pfr_fifo.sv]
// Small register queue with push/full and pop/empty sides.
module pfr_fifo
    import pfr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[hdl/pfr_front.sv]
// Front end: tracks datagram byte position, parses the header, classifies items.
module pfr_front
    import pfr_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic                                  req_type,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_of_datagram,
    input  logic [19:0]                           read_address,
    input  logic [PPF_W-1:0]                      ppf,
    input  logic [PM_W-1:0]                       pm,
    output logic                                  op_valid,
    output op_flags_t                             op_flags,
    output logic [7:0]                            op_frame,
    output logic [31:0]                           op_index,
    output logic [7:0]                            op_data,
    output logic [$clog2(STORE_BYTES)-1:0]        op_raddr,
    output logic [$clog2(STORE_BYTES + 1)-1:0]    op_base
);

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int WP_W   = $clog2(STORE_BYTES + 1);
    localparam int IDX_W  = MAX_PACKETS > 1 ? $clog2(MAX_PACKETS) : 1;
    localparam int PROD_W = IDX_W + PM_W;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        hframe_reg, hframe_next;
    logic [31:0]       hindex_reg, hindex_next;
    logic [1:0]        byte_sel;
    logic [PROD_W-1:0] prod;
    logic              dgram;

    assign dgram    = accept && !req_type;
    assign byte_sel = 2'(pos_reg - 16'd1);

    // Header assembly with this byte folded in
    always_comb
    begin
        hframe_next = hframe_reg;
        hindex_next = hindex_reg;
        if (pos_reg == '0)
        begin
            hframe_next = data_byte;
            hindex_next = '0;
        end
        else if (pos_reg < POS_W'(HEADER_BYTES))
        begin
            hindex_next = hindex_reg | (32'(data_byte) << {byte_sel, 3'b000});
        end
    end

    // Store base of the packet: index * payload_max, clamped to the store size
    assign prod    = PROD_W'(IDX_W'(hindex_next)) * PROD_W'(pm);
    assign op_base = (64'(prod) >= 64'(STORE_BYTES)) ? WP_W'(STORE_BYTES) : WP_W'(prod);

    // Classification
    always_comb
    begin
        op_flags.is_read     = req_type;
        op_flags.hdr_done    = !req_type && (pos_reg == POS_W'(HEADER_BYTES - 1));
        op_flags.payload     = !req_type && (pos_reg >= POS_W'(HEADER_BYTES));
        op_flags.last        = !req_type && last_of_datagram;
        op_flags.short_dgram = !req_type && last_of_datagram
                               && (pos_reg < POS_W'(HEADER_BYTES - 1));
        op_flags.in_window   = (POS_W'(pos_reg - POS_W'(HEADER_BYTES)) < pm);
        op_flags.in_range    = (hindex_next < 32'(ppf)) && (hindex_next < 32'(MAX_PACKETS));
        op_flags.rd_in_range = (32'(read_address) < 32'(STORE_BYTES));
    end

    // Header bytes that neither end the header nor the datagram need no back-end work
    assign op_valid = accept && (op_flags.is_read || op_flags.hdr_done
                                 || op_flags.payload || op_flags.last);
    assign op_frame = hframe_next;
    assign op_index = hindex_next;
    assign op_data  = data_byte;
    assign op_raddr = ADDR_W'(read_address);

    // Byte position, saturating
    always_comb
    begin
        pos_next = pos_reg;
        if (dgram)
        begin
            if (last_of_datagram)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hframe_reg <= '0;
            hindex_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (dgram)
            begin
                hframe_reg <= hframe_next;
                hindex_reg <= hindex_next;
            end
        end
    end

endmodule

[hdl/pfr_back.sv]
// Back end: packet map, counters, frame store writes and reads, result items.
module pfr_back
    import pfr_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  op_avail,
    output logic                                  op_pop,
    input  op_flags_t                             op_flags,
    input  logic [7:0]                            op_frame,
    input  logic [31:0]                           op_index,
    input  logic [7:0]                            op_data,
    input  logic [$clog2(STORE_BYTES)-1:0]        op_raddr,
    input  logic [$clog2(STORE_BYTES + 1)-1:0]    op_base,
    input  logic [PPF_W-1:0]                      ppf,
    input  logic [TOTAL_W-1:0]                    frame_bytes,
    input  logic                                  res_full,
    output logic                                  res_push,
    output res_t                                  res_data
);

    localparam int ADDR_W    = $clog2(STORE_BYTES);
    localparam int WP_W      = $clog2(STORE_BYTES + 1);
    localparam int IDX_W     = MAX_PACKETS > 1 ? $clog2(MAX_PACKETS) : 1;
    localparam int CNT_W     = $clog2(MAX_PACKETS + 1);
    // Packet map kept as at most 64 rows, one valid flop per row
    localparam int ROW_SH    = IDX_W > 6 ? IDX_W - 6 : 0;
    localparam int SEEN_W    = 1 << ROW_SH;
    localparam int SEEN_ROWS = (MAX_PACKETS + SEEN_W - 1) / SEEN_W;
    localparam int ROW_AW    = SEEN_ROWS > 1 ? $clog2(SEEN_ROWS) : 1;
    localparam int BIT_W     = ROW_SH > 0 ? ROW_SH : 1;

    // Execute stage op
    logic                b_valid_reg;
    op_flags_t           b_flags_reg;
    logic [7:0]          b_frame_reg;
    logic [31:0]         b_index_reg;
    logic [7:0]          b_data_reg;
    logic [ADDR_W-1:0]   b_raddr_reg;
    logic [WP_W-1:0]     b_base_reg;

    // Frame state
    logic [7:0]          current_frame_reg, current_frame_next;
    logic [CNT_W-1:0]    seen_count_reg, seen_count_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [WP_W-1:0]     wp_reg, wp_next;
    logic                accepted_reg, accepted_next;
    logic [SEEN_W-1:0]   hold_row_reg, hold_row_next;
    logic [SEEN_ROWS-1:0] row_valid_reg, row_valid_next;

    // Bypass of the last packet map row written
    logic                seen_byp_valid_reg, seen_byp_valid_next;
    logic [ROW_AW-1:0]   seen_byp_row_reg, seen_byp_row_next;
    logic [SEEN_W-1:0]   seen_byp_data_reg, seen_byp_data_next;

    // Bypass of the store write that coincided with the read issue
    logic                st_byp_valid_reg;
    logic [ADDR_W-1:0]   st_byp_addr_reg;
    logic [7:0]          st_byp_data_reg;

    // RAM ports
    logic                store_we;
    logic [ADDR_W-1:0]   store_waddr;
    logic [7:0]          store_wdata;
    logic [7:0]          store_rdata;
    logic                seen_we;
    logic [SEEN_W-1:0]   seen_wdata;
    logic [SEEN_W-1:0]   seen_rdata;
    logic [ROW_AW-1:0]   seen_raddr;

    // Execute stage helpers
    logic                b_need_res;
    logic                b_exec;
    logic [IDX_W-1:0]    b_idx_low;
    logic [ROW_AW-1:0]   b_row;
    logic [BIT_W-1:0]    b_bit;
    logic [SEEN_W-1:0]   b_onehot;
    logic [SEEN_W-1:0]   row_eff;
    logic                seen_bit;
    logic                fchg;
    logic                acc_a;
    logic [WP_W-1:0]     wp_a;
    logic [CNT_W-1:0]    cnt_a;
    logic [CNT_W-1:0]    cnt_b;
    logic [TOTAL_W-1:0]  tot_a;
    logic [SEEN_W-1:0]   hold_cur;
    logic [7:0]          rd_byte;
    logic [31:0]         target;

    // Stage advance: an op waits in execute only for room in the result queue
    assign b_need_res = b_flags_reg.is_read || b_flags_reg.last;
    assign b_exec     = b_valid_reg && (!b_need_res || !res_full);
    assign op_pop     = op_avail && (!b_valid_reg || b_exec);

    // RAM read issue for the op entering execute
    assign seen_raddr = ROW_AW'(IDX_W'(op_index) >> ROW_SH);

    pfr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (store_wdata),
        .re    (op_pop),
        .raddr (op_raddr),
        .rdata (store_rdata)
    );

    pfr_ram #(
        .WIDTH (SEEN_W),
        .DEPTH (SEEN_ROWS)
    ) u_seen (
        .clk   (clk),
        .we    (seen_we),
        .waddr (b_row),
        .wdata (seen_wdata),
        .re    (op_pop),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    // Packet map lookup of the op in execute
    assign b_idx_low = IDX_W'(b_index_reg);
    assign b_row     = ROW_AW'(b_idx_low >> ROW_SH);
    assign b_bit     = BIT_W'(b_idx_low & IDX_W'(SEEN_W - 1));
    assign b_onehot  = SEEN_W'(1) << b_bit;

    always_comb
    begin
        if (seen_byp_valid_reg && (seen_byp_row_reg == b_row))
        begin
            row_eff = seen_byp_data_reg;
        end
        else if (row_valid_reg[b_row])
        begin
            row_eff = seen_rdata;
        end
        else
        begin
            row_eff = '0;
        end
    end

    assign seen_bit = |(row_eff & b_onehot);
    assign rd_byte  = (st_byp_valid_reg && (st_byp_addr_reg == b_raddr_reg))
                      ? st_byp_data_reg : store_rdata;
    assign target   = (32'(ppf) < 32'(MAX_PACKETS)) ? 32'(ppf) : 32'(MAX_PACKETS);
    assign fchg     = b_flags_reg.hdr_done && (b_frame_reg != current_frame_reg);

    // Execute
    always_comb
    begin
        current_frame_next  = current_frame_reg;
        seen_count_next     = seen_count_reg;
        total_next          = total_reg;
        wp_next             = wp_reg;
        accepted_next       = accepted_reg;
        hold_row_next       = hold_row_reg;
        row_valid_next      = row_valid_reg;
        seen_byp_valid_next = seen_byp_valid_reg;
        seen_byp_row_next   = seen_byp_row_reg;
        seen_byp_data_next  = seen_byp_data_reg;
        store_we            = 1'b0;
        store_waddr         = ADDR_W'(wp_reg);
        store_wdata         = b_data_reg;
        seen_we             = 1'b0;
        seen_wdata          = hold_row_reg | b_onehot;
        res_push            = 1'b0;
        res_data            = '0;
        acc_a               = accepted_reg;
        wp_a                = wp_reg;
        cnt_a               = seen_count_reg;
        cnt_b               = seen_count_reg + 1'b1;
        tot_a               = total_reg;
        hold_cur            = hold_row_reg;

        if (b_exec)
        begin
            if (b_flags_reg.is_read)
            begin
                res_push                  = 1'b1;
                res_data.status           = ST_READ;
                res_data.packets_received = PPF_W'(seen_count_reg);
                res_data.bytes_received   = total_reg;
                res_data.read_byte        = b_flags_reg.rd_in_range ? rd_byte : 8'd0;
            end
            else
            begin
                // New frame id: drop the packet map and counters
                if (fchg)
                begin
                    cnt_a               = '0;
                    tot_a               = '0;
                    row_valid_next      = '0;
                    seen_byp_valid_next = 1'b0;
                    current_frame_next  = b_frame_reg;
                end

                // Header complete: duplicate check and store base
                if (b_flags_reg.hdr_done)
                begin
                    hold_cur = fchg ? '0 : row_eff;
                    acc_a    = b_flags_reg.in_range && (fchg || !seen_bit);
                    wp_a     = b_base_reg;
                end

                // Payload byte of an accepted packet
                if (b_flags_reg.payload && acc_a && b_flags_reg.in_window)
                begin
                    if (wp_a < WP_W'(STORE_BYTES))
                    begin
                        store_we    = 1'b1;
                        store_waddr = ADDR_W'(wp_a);
                        wp_a        = wp_a + 1'b1;
                    end
                    if (tot_a != TOTAL_MAX)
                    begin
                        tot_a = tot_a + 1'b1;
                    end
                end

                // End of datagram: report
                if (b_flags_reg.last)
                begin
                    cnt_b                   = cnt_a + 1'b1;
                    res_push                = 1'b1;
                    res_data.frame_id       = b_frame_reg;
                    res_data.packet_index   = b_index_reg;
                    res_data.bytes_received = tot_a;
                    if (b_flags_reg.short_dgram)
                    begin
                        res_data.status           = ST_SHORT;
                        res_data.packets_received = PPF_W'(cnt_a);
                    end
                    else if (acc_a)
                    begin
                        res_data.packets_received = PPF_W'(cnt_b);
                        if (32'(cnt_b) == target)
                        begin
                            res_data.status     = ST_COMPLETE;
                            res_data.length_ok  = (tot_a == frame_bytes);
                            cnt_a               = '0;
                            tot_a               = '0;
                            row_valid_next      = '0;
                            seen_byp_valid_next = 1'b0;
                        end
                        else
                        begin
                            res_data.status = (b_flags_reg.payload && !b_flags_reg.in_window)
                                              ? ST_OVERFLOW : ST_ACCEPTED;
                            seen_we               = 1'b1;
                            seen_wdata            = hold_cur | b_onehot;
                            row_valid_next[b_row] = 1'b1;
                            seen_byp_valid_next   = 1'b1;
                            seen_byp_row_next     = b_row;
                            seen_byp_data_next    = hold_cur | b_onehot;
                            cnt_a                 = cnt_b;
                        end
                    end
                    else
                    begin
                        res_data.status           = b_flags_reg.in_range ? ST_DUPLICATE : ST_RANGE;
                        res_data.packets_received = PPF_W'(cnt_a);
                    end
                    acc_a = 1'b0;
                end

                seen_count_next = cnt_a;
                total_next      = tot_a;
                wp_next         = wp_a;
                accepted_next   = acc_a;
                hold_row_next   = hold_cur;
            end
        end
    end

    // Control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg        <= 1'b0;
            current_frame_reg  <= '0;
            seen_count_reg     <= '0;
            total_reg          <= '0;
            wp_reg             <= '0;
            accepted_reg       <= 1'b0;
            row_valid_reg      <= '0;
            seen_byp_valid_reg <= 1'b0;
            st_byp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (op_pop)
            begin
                b_valid_reg      <= 1'b1;
                st_byp_valid_reg <= store_we;
            end
            else if (b_exec)
            begin
                b_valid_reg <= 1'b0;
            end
            current_frame_reg  <= current_frame_next;
            seen_count_reg     <= seen_count_next;
            total_reg          <= total_next;
            wp_reg             <= wp_next;
            accepted_reg       <= accepted_next;
            row_valid_reg      <= row_valid_next;
            seen_byp_valid_reg <= seen_byp_valid_next;
        end
    end

    // Op payload and bypass data
    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            b_flags_reg     <= op_flags;
            b_frame_reg     <= op_frame;
            b_index_reg     <= op_index;
            b_data_reg      <= op_data;
            b_raddr_reg     <= op_raddr;
            b_base_reg      <= op_base;
            st_byp_addr_reg <= store_waddr;
            st_byp_data_reg <= store_wdata;
        end
        hold_row_reg      <= hold_row_next;
        seen_byp_row_reg  <= seen_byp_row_next;
        seen_byp_data_reg <= seen_byp_data_next;
    end

endmodule

[hdl/packet_frame_reassembler_unit.sv]
// Top level of the packet frame reassembler: config registers, queues, front and back.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------------------
//  input     | push / full            | req_type, data_byte, last_of_datagram,
//            |                        | read_address
//  result    | pop / empty            | status, frame_id, packet_index, packets_received,
//            |                        | bytes_received, length_ok, read_byte
//  config    | psel, penable, pwrite  | paddr, pwdata, prdata, pready (always high)
//
// One item per cycle sustained; the rate is set by the single execute stage of the back
// end, which does one frame store access and one packet map access per item.
// A result passes the op queue, the execute stage and the result queue to the result ports.
// Reset clears the packet map at once through one valid flop per map row; the frame
// store has no clearing pass and reads back undefined data where never written.
// A full result queue stalls the back end only; the op queue keeps taking items until full.
module packet_frame_reassembler_unit
    import pfr_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF,
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    // input items
    input  logic                push,
    output logic                full,
    input  logic                req_type,
    input  logic [7:0]          data_byte,
    input  logic                last_of_datagram,
    input  logic [19:0]         read_address,
    // result items
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          status,
    output logic [7:0]          frame_id,
    output logic [31:0]         packet_index,
    output logic [PPF_W-1:0]    packets_received,
    output logic [TOTAL_W-1:0]  bytes_received,
    output logic                length_ok,
    output logic [7:0]          read_byte,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int WP_W        = $clog2(STORE_BYTES + 1);
    localparam int OP_Q_DEPTH  = 4;
    localparam int RES_Q_DEPTH = 2;
    localparam int OP_W        = $bits(op_flags_t) + 8 + 32 + 8 + ADDR_W + WP_W;
    localparam int RES_W       = $bits(res_t);

    logic [PPF_W-1:0]   ppf_reg;
    logic [PM_W-1:0]    pm_reg;
    logic [TOTAL_W-1:0] fb_reg;
    logic               cfg_wr;

    logic               in_accept;
    logic               f_valid;
    op_flags_t          f_flags;
    logic [7:0]         f_frame;
    logic [31:0]        f_index;
    logic [7:0]         f_data;
    logic [ADDR_W-1:0]  f_raddr;
    logic [WP_W-1:0]    f_base;

    logic [OP_W-1:0]    q_rdata;
    logic               q_empty;
    logic               q_pop;
    op_flags_t          q_flags;
    logic [7:0]         q_frame;
    logic [31:0]        q_index;
    logic [7:0]         q_data;
    logic [ADDR_W-1:0]  q_raddr;
    logic [WP_W-1:0]    q_base;

    logic               res_full;
    logic               res_push;
    res_t               res_in;
    logic [RES_W-1:0]   res_rdata;
    res_t               res_out;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppf_reg <= PPF_RST;
            pm_reg  <= PM_RST;
            fb_reg  <= FB_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_PPF: ppf_reg <= pwdata[PPF_W-1:0];
                REG_PM:  pm_reg  <= pwdata[PM_W-1:0];
                REG_FB:  fb_reg  <= pwdata[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PPF: prdata = 32'(ppf_reg);
            REG_PM:  prdata = 32'(pm_reg);
            REG_FB:  prdata = 32'(fb_reg);
            default: prdata = '0;
        endcase
    end

    // Front end
    assign in_accept = push && !full;

    pfr_front #(
        .MAX_PACKETS (MAX_PACKETS),
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (in_accept),
        .req_type         (req_type),
        .data_byte        (data_byte),
        .last_of_datagram (last_of_datagram),
        .read_address     (read_address),
        .ppf              (ppf_reg),
        .pm               (pm_reg),
        .op_valid         (f_valid),
        .op_flags         (f_flags),
        .op_frame         (f_frame),
        .op_index         (f_index),
        .op_data          (f_data),
        .op_raddr         (f_raddr),
        .op_base          (f_base)
    );

    // Op queue between front and back
    pfr_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_Q_DEPTH)
    ) u_op_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid),
        .wdata ({f_flags, f_frame, f_index, f_data, f_raddr, f_base}),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    assign {q_flags, q_frame, q_index, q_data, q_raddr, q_base} = q_rdata;

    // Back end
    pfr_back #(
        .MAX_PACKETS (MAX_PACKETS),
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_avail    (!q_empty),
        .op_pop      (q_pop),
        .op_flags    (q_flags),
        .op_frame    (q_frame),
        .op_index    (q_index),
        .op_data     (q_data),
        .op_raddr    (q_raddr),
        .op_base     (q_base),
        .ppf         (ppf_reg),
        .frame_bytes (fb_reg),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_data    (res_in)
    );

    // Result queue
    pfr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_Q_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out          = res_t'(res_rdata);
    assign status           = res_out.status;
    assign frame_id         = res_out.frame_id;
    assign packet_index     = res_out.packet_index;
    assign packets_received = res_out.packets_received;
    assign bytes_received   = res_out.bytes_received;
    assign length_ok        = res_out.length_ok;
    assign read_byte        = res_out.read_byte;

endmodule

[bench/tb.sv]
// Self-checking testbench for the packet frame reassembler: queued stimulus, predictor, checker.
`timescale 1ns / 100ps

module tb;
    import pfr_pkg::*;

    localparam int QUIET_CYCLES = 16;    // settle time before touching the registers
    localparam int HOLD_CYCLES  = 800;   // one long receiver hold-off
    localparam int STUCK_LIMIT  = 4000;  // cycles with no handshake before giving up
    localparam int MAX_PRINTS   = 40;

    // One input item as the sender offers it
    typedef struct {
        bit        req;
        bit [7:0]  data;
        bit        last;
        bit [19:0] addr;
    } pkt_item_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                full;
    logic                req_type = 1'b0;
    logic [7:0]          data_byte = 8'h00;
    logic                last_of_datagram = 1'b0;
    logic [19:0]         read_address = 20'h00000;
    logic                empty;
    logic                pop = 1'b0;
    logic [2:0]          status;
    logic [7:0]          frame_id;
    logic [31:0]         packet_index;
    logic [PPF_W-1:0]    packets_received;
    logic [TOTAL_W-1:0]  bytes_received;
    logic                length_ok;
    logic [7:0]          read_byte;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = 4'h0;
    logic [31:0]         pwdata = 32'h0;
    logic [31:0]         prdata;
    logic                pready;

    packet_frame_reassembler_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .req_type         (req_type),
        .data_byte        (data_byte),
        .last_of_datagram (last_of_datagram),
        .read_address     (read_address),
        .empty            (empty),
        .pop              (pop),
        .status           (status),
        .frame_id         (frame_id),
        .packet_index     (packet_index),
        .packets_received (packets_received),
        .bytes_received   (bytes_received),
        .length_ok        (length_ok),
        .read_byte        (read_byte),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #4 clk = ~clk;

    // Items waiting to be offered, and reports still owed by the block
    pkt_item_t outgoing_items[$];
    res_t      owed_reports[$];
    int        items_queued = 0;
    int        err_count = 0;
    int        reports_seen = 0;
    bit        hold_wanted = 1'b0;

    // Register copies
    bit [PPF_W-1:0]   cfg_ppf;
    bit [PM_W-1:0]    cfg_pm;
    bit [TOTAL_W-1:0] cfg_fb;

    // Reassembly state as the predictor sees it
    bit [POS_W-1:0]   sh_pos;
    bit [7:0]         sh_cur_frame;
    bit [7:0]         sh_hdr_frame;
    bit [31:0]        sh_hdr_index;
    bit               sh_seen [MAX_PACKETS_DEF];
    bit [PPF_W-1:0]   sh_seen_cnt;
    bit [TOTAL_W-1:0] sh_total;
    bit [20:0]        sh_wptr;
    bit               sh_accepted;
    byte unsigned     sh_store [int unsigned];
    int unsigned      sh_written[$];

    task automatic note_error(input string msg);
        if (err_count < MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_error($sformatf("report %0d %s got %0h want %0h", reports_seen, name,
                                 got, want));
    endtask

    function automatic bit idx_in_frame(input bit [31:0] idx);
        return (idx < {21'd0, cfg_ppf}) && (idx < 32'(MAX_PACKETS_DEF));
    endfunction

    task automatic clear_frame_map();
        foreach (sh_seen[i])
            sh_seen[i] = 1'b0;
        sh_seen_cnt = '0;
        sh_total = '0;
    endtask

    // Predictor: consume one accepted item, queue the report it causes
    task automatic reassemble_item(input pkt_item_t it);
        res_t            r;
        bit [POS_W-1:0]  pos;
        bit [31:0]       offs;
        bit [63:0]       base;
        bit [PPF_W-1:0]  tgt;
        r = '0;
        if (it.req) begin
            r.status = ST_READ;
            r.packets_received = sh_seen_cnt;
            r.bytes_received = sh_total;
            r.read_byte = sh_store.exists(it.addr) ? sh_store[it.addr] : 8'h00;
            owed_reports.insert(owed_reports.size(), r);
            return;
        end
        pos = sh_pos;
        if (pos == 0) begin
            sh_hdr_frame = it.data;
            sh_hdr_index = '0;
        end
        else if (pos < HEADER_BYTES) begin
            sh_hdr_index |= 32'(it.data) << (8 * (pos - 1));
            // header complete: frame switch, acceptance, store base
            if (pos == HEADER_BYTES - 1) begin
                if (sh_hdr_frame != sh_cur_frame) begin
                    clear_frame_map();
                    sh_cur_frame = sh_hdr_frame;
                end
                sh_accepted = idx_in_frame(sh_hdr_index) ? !sh_seen[sh_hdr_index[9:0]] : 1'b0;
                base = 64'(sh_hdr_index) * 64'(cfg_pm);
                sh_wptr = (base < 64'(STORE_BYTES_DEF)) ? base[20:0] : 21'(STORE_BYTES_DEF);
            end
        end
        else begin
            // payload byte: stored within the window, counted even past the store end
            offs = 32'(pos) - HEADER_BYTES;
            if (sh_accepted && offs < 32'(cfg_pm)) begin
                if (sh_wptr < 21'(STORE_BYTES_DEF)) begin
                    if (!sh_store.exists(sh_wptr))
                        sh_written.insert(sh_written.size(), 32'(sh_wptr));
                    sh_store[sh_wptr] = it.data;
                    sh_wptr++;
                end
                if (sh_total != TOTAL_MAX)
                    sh_total++;
            end
        end
        if (sh_pos != POS_MAX)
            sh_pos++;
        if (!it.last)
            return;

        // datagram end
        sh_pos = '0;
        r.frame_id = sh_hdr_frame;
        r.packet_index = sh_hdr_index;
        r.packets_received = sh_seen_cnt;
        if (pos < HEADER_BYTES - 1)
            r.status = ST_SHORT;
        else if (sh_accepted && idx_in_frame(sh_hdr_index)) begin
            sh_seen[sh_hdr_index[9:0]] = 1'b1;
            sh_seen_cnt++;
            r.packets_received = sh_seen_cnt;
            tgt = (cfg_ppf < PPF_W'(MAX_PACKETS_DEF)) ? cfg_ppf : PPF_W'(MAX_PACKETS_DEF);
            if (sh_seen_cnt == tgt) begin
                r.status = ST_COMPLETE;
                r.length_ok = (sh_total == cfg_fb);
            end
            else if (32'(pos) + 1 > HEADER_BYTES + 32'(cfg_pm))
                r.status = ST_OVERFLOW;
            else
                r.status = ST_ACCEPTED;
        end
        else
            r.status = idx_in_frame(sh_hdr_index) ? ST_DUPLICATE : ST_RANGE;
        sh_accepted = 1'b0;
        r.bytes_received = sh_total;
        owed_reports.insert(owed_reports.size(), r);
        if (r.status == ST_COMPLETE)
            clear_frame_map();
    endtask

    // Sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge clk) begin
        bit go;
        go = 1'b0;
        if (rst_n && outgoing_items.size() != 0) begin
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 48);
                case ($urandom_range(0, 5))
                    0, 1, 2: gap_left = 0;
                    3, 4:    gap_left = $urandom_range(1, 3);
                    default: gap_left = $urandom_range(4, 16);
                endcase
            end
            if (burst_left != 0) begin
                burst_left--;
                go = 1'b1;
            end
            else
                gap_left--;
        end
        push <= go;
        if (go) begin
            req_type <= outgoing_items[0].req;
            data_byte <= outgoing_items[0].data;
            last_of_datagram <= outgoing_items[0].last;
            read_address <= outgoing_items[0].addr;
        end
    end

    // Receiver: stall pattern of its own, plus one long hold-off
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  stall_run = 0;
    int  stall_mode = 0;
    always @(negedge clk) begin
        bit take;
        take = 1'b1;
        if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
        end
        else if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            take = 1'b0;
        end
        else begin
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_run = $urandom_range(16, 160);
            end
            else
                stall_run--;
            case (stall_mode)
                1:       take = ($urandom_range(0, 3) != 0);
                2:       take = ($urandom_range(0, 2) == 0);
                default: take = 1'b1;
            endcase
        end
        pop <= take;
    end

    // Monitor: check reports first, then predict from the accepted item
    always @(posedge clk) begin
        pkt_item_t got_item;
        res_t      w;
        if (rst_n && pop && !empty) begin
            if (owed_reports.size() == 0)
                note_error($sformatf("report %0d with none owed, status %0d",
                                     reports_seen, status));
            else begin
                w = owed_reports[0];
                owed_reports.delete(0);
                check_field("status", 32'(status), 32'(w.status));
                check_field("frame_id", 32'(frame_id), 32'(w.frame_id));
                check_field("packet_index", packet_index, w.packet_index);
                check_field("packets_received", 32'(packets_received), 32'(w.packets_received));
                check_field("bytes_received", 32'(bytes_received), 32'(w.bytes_received));
                check_field("length_ok", 32'(length_ok), 32'(w.length_ok));
                check_field("read_byte", 32'(read_byte), 32'(w.read_byte));
            end
            reports_seen++;
        end
        if (rst_n && push && !full) begin
            got_item.req = req_type;
            got_item.data = data_byte;
            got_item.last = last_of_datagram;
            got_item.addr = read_address;
            outgoing_items.delete(0);
            reassemble_item(got_item);
        end
    end

    // Watchdog on handshake activity
    int stuck_cycles = 0;
    always @(posedge clk) begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("[packet_frame_reassembler_unit] ERROR");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic queue_item(input bit req, input bit [7:0] data, input bit last,
                              input bit [19:0] addr);
        pkt_item_t it;
        it.req = req;
        it.data = data;
        it.last = last;
        it.addr = addr;
        outgoing_items.insert(outgoing_items.size(), it);
        items_queued++;
    endtask

    task automatic queue_read(input bit [19:0] addr);
        queue_item(1'b1, 8'($urandom), 1'($urandom), addr);
    endtask

    // read a byte known to be written already
    task automatic queue_random_read();
        if (sh_written.size() != 0)
            queue_read(20'(sh_written[$urandom_range(0, sh_written.size() - 1)]));
    endtask

    // header plus plen payload bytes, with the odd store read slipped in
    task automatic queue_dgram(input bit [7:0] fid, input bit [31:0] idx, input int plen);
        int       total;
        bit [7:0] b;
        total = HEADER_BYTES + plen;
        for (int k = 0; k < total; k++) begin
            if (k > 0 && $urandom_range(0, 24) == 0)
                queue_random_read();
            if (k == 0)
                b = fid;
            else if (k < HEADER_BYTES)
                b = idx[8 * (k - 1) +: 8];
            else
                b = 8'($urandom);
            queue_item(1'b0, b, k == total - 1, 20'($urandom));
        end
    endtask

    task automatic write_reg(input logic [1:0] widx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {widx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        case (widx)
            REG_PPF: cfg_ppf = val[PPF_W-1:0];
            REG_PM:  cfg_pm = val[PM_W-1:0];
            default: cfg_fb = val[TOTAL_W-1:0];
        endcase
        // read back
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== val)
            note_error($sformatf("register %0d reads %0h, wrote %0h", widx, prdata, val));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for the block to go idle, then load a new setting
    task automatic drain_then_configure(input int ppf, input int pm, input int fb);
        while (outgoing_items.size() != 0 || owed_reports.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        write_reg(REG_PPF, 32'(ppf));
        write_reg(REG_PM, 32'(pm));
        write_reg(REG_FB, 32'(fb));
    endtask

    // mostly well-formed frames, some noise, short datagrams and reads
    task automatic run_random_phase(input int n_items);
        int        start, pick, plen, span, gen_left;
        bit [7:0]  gen_frame;
        bit        gen_sent [16];
        bit [31:0] idx;
        start = items_queued;
        span = (cfg_ppf == 0) ? 1 : ((cfg_ppf > 16) ? 16 : int'(cfg_ppf));
        gen_left = 0;
        gen_frame = 8'($urandom);
        while (items_queued - start < n_items) begin
            while (outgoing_items.size() >= 4)
                @(posedge clk);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                queue_random_read();
            else if (pick < 14) begin
                // header cut short
                plen = $urandom_range(1, HEADER_BYTES - 1);
                for (int k = 0; k < plen; k++)
                    queue_item(1'b0, 8'($urandom), k == plen - 1, 20'($urandom));
            end
            else if (pick < 22) begin
                // noise: wild index or just past the frame
                idx = $urandom_range(0, 1) ? $urandom : 32'(cfg_ppf) + $urandom_range(0, 3);
                queue_dgram($urandom_range(0, 1) ? gen_frame : 8'($urandom), idx,
                            $urandom_range(0, int'(cfg_pm) + 3));
            end
            else begin
                if (gen_left == 0 || $urandom_range(0, 29) == 0) begin
                    gen_frame = 8'($urandom);
                    foreach (gen_sent[i])
                        gen_sent[i] = 1'b0;
                    gen_left = span;
                end
                if ($urandom_range(0, 7) == 0)
                    idx = $urandom_range(0, span - 1);
                else begin
                    do
                        idx = $urandom_range(0, span - 1);
                    while (gen_sent[idx[3:0]]);
                    gen_sent[idx[3:0]] = 1'b1;
                    gen_left--;
                end
                case ($urandom_range(0, 19))
                    0, 1, 2: plen = $urandom_range(0, int'(cfg_pm));
                    3, 4, 5: plen = int'(cfg_pm) + $urandom_range(1, 3);
                    default: plen = int'(cfg_pm);
                endcase
                queue_dgram(gen_frame, idx, plen);
            end
        end
    endtask

    // Test sequence
    initial begin
        int ppf, pm, fb;
        cfg_ppf = PPF_RST;
        cfg_pm = PM_RST;
        cfg_fb = FB_RST;
        sh_pos = '0;
        sh_cur_frame = '0;
        sh_hdr_frame = '0;
        sh_hdr_index = '0;
        sh_wptr = '0;
        sh_accepted = 1'b0;
        clear_frame_map();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: short headers, accept, range, duplicate, read
        queue_item(1'b0, 8'h00, 1'b1, 20'h00000);
        for (int k = 0; k < 4; k++)
            queue_item(1'b0, 8'hFF, k == 3, 20'hFFFFF);
        queue_dgram(8'h00, 32'd0, 0);
        queue_dgram(8'h00, 32'hFFFF_FFFF, 0);
        queue_dgram(8'h00, 32'd0, 2);
        queue_dgram(8'h00, 32'd1, 3);
        queue_read(20'd1401);

        // tiny frame: excess payload, then completion with matching length
        drain_then_configure(2, 2, 4);
        queue_dgram(8'h07, 32'd0, 3);
        queue_dgram(8'h07, 32'd1, 2);
        run_random_phase(100);

        // lowest setting: every packet completes a frame
        drain_then_configure(1, 1, 1);
        run_random_phase(50);

        // zero packets per frame and zero payload: nothing accepted
        drain_then_configure(0, 0, 2097151);
        run_random_phase(30);

        // widest stride: store end and map bound
        drain_then_configure(2047, 65535, 1048576);
        queue_dgram(8'h5A, 32'd16, 20);
        queue_dgram(8'h5A, 32'd1023, 0);
        queue_dgram(8'h5A, 32'd1024, 0);
        queue_read(20'hFFFFF);
        queue_read(20'd1048560);

        // random small settings; the third one runs under a long receiver hold-off
        for (int ph = 0; ph < 4; ph++) begin
            ppf = $urandom_range(1, 6);
            pm = (ph == 2) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            fb = $urandom_range(0, 1) ? ppf * pm : $urandom_range(1, ppf * pm + 4);
            drain_then_configure(ppf, pm, fb);
            if (ph == 2)
                hold_wanted = 1'b1;
            run_random_phase((ph == 2) ? 300 : 80);
        end

        // drain and let the pipeline settle
        while (outgoing_items.size() != 0 || owed_reports.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("[packet_frame_reassembler_unit] OK");
        else
            $display("[packet_frame_reassembler_unit] ERROR");
        $finish;
    end

endmodule
